@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the bit field reader RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/bfr_pkg.sv @@
// Package for the bit field reader: widths, command codes, status codes,
// controller/datapath interface structs. No dependencies.
package bfr_pkg;
    localparam int CAP       = 1024;
    localparam int AW        = 10;
    localparam int CW        = 11;
    localparam int MAX_FIELD = 32;
    localparam int MAX_CHARS = 32;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_SETPOS = 3'd2,
        CMD_SKIP   = 3'd3,
        CMD_READU  = 3'd4,
        CMD_READS  = 3'd5,
        CMD_READSTR = 3'd6,
        CMD_NOP    = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_LEN   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic       load;      // latch the input item
        logic       exec;      // apply simple command
        logic       rd_bit;    // shift one stored bit into the accumulator
        logic       str_init;  // prepare string walk
        logic       str_bit;   // shift one string bit
        logic       str_push;  // push decoded char into text buffer
        logic       finish;    // commit cursor for reads
        logic       out_pop;   // emit next string char
    } dp_cmd_t;

    typedef struct packed {
        logic       is_field;
        logic       is_str;
        logic       err;
        logic       field_done;
        logic       group_done;
        logic       str_done;
        logic       out_done;
        logic       out_empty;
    } dp_stat_t;
endpackage

@@ hw/rtl/bfr_datapath.sv @@
// Datapath of the bit field reader: bit store, count, cursor, accumulator,
// string buffer and status register. Depends on bfr_pkg.
module bfr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        cmd,
    input  logic              use_cursor,
    input  logic [10:0]       start_req,
    input  logic [10:0]       length,
    input  logic [7:0]        char_in,
    input  bfr_pkg::dp_cmd_t  ctl,
    output bfr_pkg::dp_stat_t stat,
    output logic [32:0]       value,
    output logic [6:0]        text_char,
    output logic              char_valid,
    output logic [1:0]        status,
    output logic [10:0]       cursor_now,
    output logic [10:0]       bit_total,
    output logic              last
);
    import bfr_pkg::*;

    logic         mem [CAP];
    logic         mem_q;
    logic [CW-1:0] count_reg, cursor_reg;
    logic [2:0]    cmd_reg;
    logic          usec_reg;
    logic [CW-1:0] sreq_reg, len_reg;
    logic [7:0]    ch_reg;
    logic [CW-1:0] addr_reg;
    logic [CW-1:0] left_reg;
    logic [31:0]   acc_reg;
    logic [5:0]    grp_reg;
    logic [2:0]    gbit_reg;
    logic [5:0]    ngrp_reg;
    logic [6:0]    text_reg [MAX_CHARS];
    logic [5:0]    n_reg;
    logic [5:0]    nt_reg;
    logic [5:0]    oidx_reg;
    logic          stop_reg;
    logic [1:0]    err_reg;

    logic [CW-1:0] start_w;
    logic [CW:0]   end_w;
    logic          range_bad;
    logic [6:0]    gchar;
    logic          is_bit;
    logic [5:0]    grp_next;
    logic [CW-1:0] rd_addr;
    logic [17:0]   div6_w;

    assign start_w   = usec_reg ? cursor_reg : sreq_reg;
    assign end_w     = {1'b0, start_w} + {1'b0, len_reg};
    assign range_bad = end_w > {1'b0, count_reg};
    assign is_bit    = (ch_reg == 8'h31) || (ch_reg == 8'h30);
    assign grp_next  = {grp_reg[4:0], mem_q};
    assign gchar     = (grp_next < 6'd32) ? {1'b0, grp_next} + 7'd64 : {1'b0, grp_next};
    assign rd_addr   = (ctl.rd_bit || ctl.str_bit) ? addr_reg + 1'b1 : addr_reg;
    // length / 6 for lengths below 192 by reciprocal multiplication
    assign div6_w    = {10'd0, len_reg[7:0]} * 18'd171;

    always_ff @(posedge clk)
    begin
        if (ctl.exec && cmd_reg == CMD_APPEND && is_bit && count_reg < CW'(CAP))
        begin
            mem[count_reg[AW-1:0]] <= ch_reg[0];
        end
        mem_q <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
            err_reg    <= ST_OK;
        end
        else
        begin
            if (ctl.load)
            begin
                cmd_reg  <= cmd;
                usec_reg <= use_cursor;
                sreq_reg <= start_req;
                len_reg  <= length;
                ch_reg   <= char_in;
            end
            if (ctl.exec)
            begin
                err_reg <= ST_OK;
                unique case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        count_reg  <= '0;
                        cursor_reg <= '0;
                    end
                    CMD_APPEND:
                    begin
                        if (is_bit)
                        begin
                            if (count_reg >= CW'(CAP))
                                err_reg <= ST_FULL;
                            else
                                count_reg <= count_reg + 1'b1;
                        end
                    end
                    CMD_SETPOS:
                    begin
                        if (sreq_reg > count_reg)
                            err_reg <= ST_RANGE;
                        else
                            cursor_reg <= sreq_reg;
                    end
                    CMD_SKIP:
                    begin
                        if ({1'b0, cursor_reg} + {1'b0, len_reg} > {1'b0, count_reg})
                            err_reg <= ST_RANGE;
                        else
                            cursor_reg <= cursor_reg + len_reg;
                    end
                    CMD_READU, CMD_READS, CMD_READSTR:
                    begin
                        if (range_bad)
                            err_reg <= ST_RANGE;
                        else if (cmd_reg != CMD_READSTR && len_reg > CW'(MAX_FIELD))
                            err_reg <= ST_LEN;
                    end
                    default: ;
                endcase
                addr_reg <= start_w;
                left_reg <= len_reg;
                acc_reg  <= '0;
            end
            if (ctl.rd_bit)
            begin
                acc_reg  <= {acc_reg[30:0], mem_q};
                left_reg <= left_reg - 1'b1;
                addr_reg <= addr_reg + 1'b1;
            end
            if (ctl.str_init)
            begin
                ngrp_reg <= (len_reg >= CW'(6 * MAX_CHARS)) ? 6'(MAX_CHARS) : div6_w[15:10];
                n_reg    <= '0;
                nt_reg   <= '0;
                oidx_reg <= '0;
                gbit_reg <= '0;
                grp_reg  <= '0;
                stop_reg <= 1'b0;
            end
            if (ctl.str_bit)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (ctl.str_push)
                begin
                    gbit_reg <= '0;
                    grp_reg  <= '0;
                end
                else
                begin
                    grp_reg  <= grp_next;
                    gbit_reg <= gbit_reg + 1'b1;
                end
            end
            if (ctl.str_push)
            begin
                ngrp_reg <= ngrp_reg - 1'b1;
                if (grp_next == 6'd0)
                    stop_reg <= 1'b1;
                else
                begin
                    text_reg[n_reg[4:0]] <= gchar;
                    n_reg <= n_reg + 1'b1;
                    if (gchar != 7'h20)
                        nt_reg <= n_reg + 1'b1;
                end
            end
            if (ctl.finish && err_reg == ST_OK && usec_reg)
                cursor_reg <= cursor_reg + len_reg;
            if (ctl.out_pop)
                oidx_reg <= oidx_reg + 1'b1;
        end
    end

    logic [32:0] ext_v;
    always_comb
    begin
        ext_v = {1'b0, acc_reg};
        if (cmd_reg == CMD_READS && len_reg != '0 && acc_reg[len_reg[4:0] - 5'd1])
            ext_v = {1'b0, acc_reg} - (33'd1 << len_reg[5:0]);
    end

    assign stat.is_field   = (cmd_reg == CMD_READU) || (cmd_reg == CMD_READS);
    assign stat.is_str     = cmd_reg == CMD_READSTR;
    assign stat.err        = err_reg != ST_OK;
    assign stat.field_done = left_reg == '0;
    assign stat.group_done = gbit_reg == 3'd5;
    assign stat.str_done   = stop_reg || ngrp_reg == '0;
    assign stat.out_done   = oidx_reg + 1'b1 >= nt_reg;
    assign stat.out_empty  = nt_reg == '0 || err_reg != ST_OK;

    logic out_char;
    assign out_char = stat.is_str && !stat.out_empty;
    assign value      = (stat.is_field && !stat.err) ? ext_v : '0;
    assign text_char  = out_char ? text_reg[oidx_reg[4:0]] : '0;
    assign char_valid = out_char;
    assign status     = err_reg;
    assign cursor_now = cursor_reg;
    assign bit_total  = count_reg;
    assign last       = !out_char || stat.out_done;
endmodule

@@ hw/rtl/bfr_ctrl.sv @@
// Controller state machine of the bit field reader.
// Depends on bfr_pkg.
module bfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_ready,
    input  bfr_pkg::dp_stat_t stat,
    output bfr_pkg::dp_cmd_t  ctl,
    output logic              in_ready,
    output logic              out_valid
);
    import bfr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_EXEC  = 8'b00000010,
        S_FWAIT = 8'b00000100,
        S_FBIT  = 8'b00001000,
        S_SWAIT = 8'b00010000,
        S_SBIT  = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_fire;

    assign out_fire  = out_valid && out_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.load = in_fire;
                if (in_fire)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (stat.err || !(stat.is_field || stat.is_str))
                    state_next = S_OUT;
                else if (stat.is_str)
                begin
                    ctl.str_init = 1'b1;
                    state_next   = S_SWAIT;
                end
                else
                    state_next = S_FBIT;
            end
            S_FBIT:
            begin
                if (stat.field_done)
                    state_next = S_FIN;
                else
                    ctl.rd_bit = 1'b1;
            end
            S_SWAIT:
            begin
                if (stat.str_done)
                    state_next = S_FIN;
                else
                    state_next = S_SBIT;
            end
            S_SBIT:
            begin
                if (stat.group_done)
                begin
                    ctl.str_push = 1'b1;
                    ctl.str_bit  = 1'b1;
                    state_next   = S_SWAIT;
                end
                else
                    ctl.str_bit = 1'b1;
            end
            S_FIN:
            begin
                ctl.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    if (!stat.is_str || stat.out_empty || stat.out_done)
                        state_next = S_IDLE;
                    else
                        ctl.out_pop = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

@@ hw/rtl/bit_field_reader_core.sv @@
// Top level of the bit field reader: controller plus datapath.
// Depends on bfr_pkg, bfr_ctrl, bfr_datapath, assert_macros.svh.
//
// Channel    Dir  tdata / tuser
// s_axis     in   tdata {char_in, length, start_req, use_cursor, cmd}
// m_axis     out  tdata {total,cursor,status,valid,char,value}, tlast
//
// Simple commands and failed reads go from execute to output; field reads
// shift one stored bit per cycle through the single memory read port.
// String reads walk the store in six-bit groups, one result per transfer.
// Reset clears count, cursor and status; store contents stay undefined.
// Input is held off until all results of the item have transferred.
`include "assert_macros.svh"
module bit_field_reader_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], use_cursor[3], start_req[14:4], length[25:15], char_in[33:26]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // value[32:0], text_char[39:33], char_valid[40], status[42:41],
    // cursor_now[53:43], bit_total[64:54]
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import bfr_pkg::*;

    dp_cmd_t     ctl;
    dp_stat_t    stat;
    logic [32:0] value;
    logic [6:0]  text_char;
    logic        char_valid;
    logic [1:0]  status;
    logic [10:0] cursor_now, bit_total;

    bfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .ctl       (ctl),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    bfr_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (s_axis_tdata[2:0]),
        .use_cursor (s_axis_tdata[3]),
        .start_req  (s_axis_tdata[14:4]),
        .length     (s_axis_tdata[25:15]),
        .char_in    (s_axis_tdata[33:26]),
        .ctl        (ctl),
        .stat       (stat),
        .value      (value),
        .text_char  (text_char),
        .char_valid (char_valid),
        .status     (status),
        .cursor_now (cursor_now),
        .bit_total  (bit_total),
        .last       (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, bit_total, cursor_now, status, char_valid, text_char, value};

    `ASSERT_IMPL(a_no_overlap, clk, rst_n, s_axis_tready, !m_axis_tvalid)
    `ASSERT_IMPL(a_cursor_in_range, clk, rst_n, 1'b1, cursor_now <= bit_total)
    `ASSERT_IMPL(a_char_ok_status, clk, rst_n, m_axis_tvalid && char_valid, status == ST_OK)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
